// File: sv/ole_pkg.sv
`timescale 1ns / 1ps
package ole_pkg;
    localparam int DEF_CAPACITY = 256;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_END   = 3'd1;
    localparam logic [2:0] OP_INS_AFTER = 3'd2;
    localparam logic [2:0] OP_DEL_VALUE = 3'd3;
    localparam logic [2:0] OP_DEL_FIRST = 3'd4;
    localparam logic [2:0] OP_SEARCH    = 3'd5;
    localparam logic [2:0] OP_READ_AT   = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_BAD_POS  = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request
        logic init_step; // write one free-stack entry during clearing pass
        logic walk_start;
        logic walk_step; // issue read of current node
        logic walk_eval; // evaluate read data
        logic commit;    // perform list update
        logic deliver;   // latch result
    } ole_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic init_done;
        logic walk_done;
        logic need_walk;
    } ole_stat_t;
endpackage

// File: sv/ole_ctrl.sv
`timescale 1ns / 1ps
module ole_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ole_pkg::ole_stat_t stat,
    output ole_pkg::ole_cmd_t  cmd
);
    import ole_pkg::*;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    // next request may enter while the result waits in the output register
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next = state_reg;
        mvalid_next = mvalid_reg;
        cmd = '0;
        if (mvalid_reg && m_ready) mvalid_next = 1'b0;
        case (state_reg)
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (stat.init_done) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC: begin
                cmd.walk_start = 1'b1;
                state_next = stat.need_walk ? S_READ : S_DONE;
            end
            S_READ: begin
                if (stat.walk_done) state_next = S_DONE;
                else begin
                    cmd.walk_step = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL: begin
                cmd.walk_eval = 1'b1;
                state_next = S_READ;
            end
            S_DONE: begin
                if (!mvalid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    cmd.deliver = 1'b1;
                    mvalid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> !s_ready) else $error("ready outside idle");
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && state_reg == S_DONE) |=> (state_reg == S_DONE))
        else $error("result overwritten");
    a_eval_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EVAL) |-> $past(state_reg == S_READ))
        else $error("eval without read");
endmodule

// File: sv/ole_datapath.sv
`timescale 1ns / 1ps
module ole_datapath #(
    parameter int LIST_CAPACITY = ole_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH   = ole_pkg::DEF_VALUE_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ole_pkg::ole_cmd_t  cmd,
    output ole_pkg::ole_stat_t stat,
    input  logic [2:0]         s_op,
    input  logic signed [31:0] s_item_value,
    input  logic signed [31:0] s_anchor_value,
    input  logic [8:0]         s_position,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_read_value,
    output logic [8:0]         m_entry_count
);
    import ole_pkg::*;

    localparam int AW = (LIST_CAPACITY > 1) ? $clog2(LIST_CAPACITY) : 1;
    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(LIST_CAPACITY);

    logic [VALUE_WIDTH-1:0] values_mem [LIST_CAPACITY];
    logic [AW-1:0]          links_mem  [LIST_CAPACITY];
    logic [AW-1:0]          free_mem   [LIST_CAPACITY];

    logic [CW-1:0] free_top_reg, count_reg, init_reg, idx_reg, pos_reg;
    logic [AW-1:0] head_reg, tail_reg, cur_reg, prev_reg, hit_reg, hit_link_reg;
    logic [2:0]    op_reg;
    logic [VALUE_WIDTH-1:0] key_reg, item_reg, rd_val_reg, found_val_reg;
    logic [AW-1:0] rd_link_reg, free_slot_reg;
    logic          found_reg, done_reg;
    logic [1:0]    status_reg;
    logic signed [31:0] read_value_reg;
    logic [8:0]    count_out_reg;

    logic full, is_ins, is_read;
    assign full = (count_reg >= CAP) || (free_top_reg == '0);
    assign is_ins = (op_reg == OP_INS_FRONT) || (op_reg == OP_INS_END) ||
                    (op_reg == OP_INS_AFTER);
    assign is_read = (op_reg == OP_READ_AT);

    assign stat.init_done = (init_reg == CAP - 1'b1);
    assign stat.walk_done = done_reg;
    assign stat.need_walk = ((op_reg == OP_INS_AFTER) && !full) ||
                            (op_reg == OP_DEL_VALUE) || (op_reg == OP_SEARCH) ||
                            (is_read && pos_reg != '0 && pos_reg <= count_reg);

    // second link write port for tail/anchor/prev updates
    logic          lw_en;
    logic [AW-1:0] lw_addr, lw_data;
    always_comb begin
        lw_en = 1'b0; lw_addr = hit_reg; lw_data = free_slot_reg;
        if (cmd.commit && is_ins && !full && count_reg != '0) begin
            if (op_reg == OP_INS_END) begin
                lw_en = 1'b1; lw_addr = tail_reg;
            end else if (op_reg == OP_INS_AFTER && found_reg) begin
                lw_en = 1'b1; lw_addr = hit_reg;
            end
        end else if (cmd.commit && op_reg == OP_DEL_VALUE && found_reg &&
                     hit_reg != head_reg) begin
            lw_en = 1'b1; lw_addr = prev_reg; lw_data = hit_link_reg;
        end
    end

    // memories: registered read ports; the link store has a second one for the head link
    always_ff @(posedge aclk) begin
        if (cmd.walk_step) begin
            rd_val_reg  <= values_mem[cur_reg];
            rd_link_reg <= links_mem[cur_reg];
        end
        if (cmd.walk_start) free_slot_reg <= free_mem[AW'(free_top_reg - 1'b1)];
        if (cmd.init_step) free_mem[init_reg[AW-1:0]] <= init_reg[AW-1:0];
        if (cmd.commit) begin
            if (is_ins && !full && !(op_reg == OP_INS_AFTER && !found_reg)) begin
                values_mem[free_slot_reg] <= item_reg;
                if (count_reg != '0) begin
                    if (op_reg == OP_INS_FRONT) links_mem[free_slot_reg] <= head_reg;
                    else if (op_reg == OP_INS_AFTER) links_mem[free_slot_reg] <= hit_link_reg;
                end
            end else if ((op_reg == OP_DEL_VALUE && found_reg) ||
                         (op_reg == OP_DEL_FIRST && count_reg != '0)) begin
                if (free_top_reg < CAP) free_mem[free_top_reg[AW-1:0]] <=
                    (op_reg == OP_DEL_FIRST) ? head_reg : hit_reg;
            end
        end
        if (lw_en) links_mem[lw_addr] <= lw_data;
    end

    // the head link is looked up at walk start and held in head_link_reg for a delete-first
    logic [AW-1:0] head_link_reg;
    always_ff @(posedge aclk) begin
        if (cmd.walk_start) head_link_reg <= links_mem[head_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_reg <= '0;
            free_top_reg <= CAP;
            count_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
        end else begin
            if (cmd.init_step && !stat.init_done) init_reg <= init_reg + 1'b1;
            if (cmd.commit) begin
                if (is_ins && !full && !(op_reg == OP_INS_AFTER && !found_reg)) begin
                    free_top_reg <= free_top_reg - 1'b1;
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == '0) begin
                        head_reg <= free_slot_reg; tail_reg <= free_slot_reg;
                    end else if (op_reg == OP_INS_FRONT) head_reg <= free_slot_reg;
                    else if (op_reg == OP_INS_END) tail_reg <= free_slot_reg;
                    else if (hit_reg == tail_reg) tail_reg <= free_slot_reg;
                end else if (op_reg == OP_DEL_FIRST && count_reg != '0) begin
                    head_reg <= head_link_reg;
                    count_reg <= count_reg - 1'b1;
                    if (free_top_reg < CAP) free_top_reg <= free_top_reg + 1'b1;
                end else if (op_reg == OP_DEL_VALUE && found_reg) begin
                    if (hit_reg == head_reg) head_reg <= hit_link_reg;
                    else if (hit_reg == tail_reg) tail_reg <= prev_reg;
                    count_reg <= count_reg - 1'b1;
                    if (free_top_reg < CAP) free_top_reg <= free_top_reg + 1'b1;
                end
            end
        end
    end

    // request capture and list walk
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_op;
            item_reg <= VALUE_WIDTH'($unsigned(s_item_value));
            key_reg  <= (s_op == OP_INS_AFTER) ? VALUE_WIDTH'($unsigned(s_anchor_value))
                                               : VALUE_WIDTH'($unsigned(s_item_value));
            pos_reg  <= CW'(s_position);
        end
        if (cmd.walk_start) begin
            cur_reg <= head_reg; prev_reg <= head_reg;
            idx_reg <= '0; found_reg <= 1'b0;
            done_reg <= (count_reg == '0);
        end
        if (cmd.walk_eval) begin
            if (is_read ? (idx_reg + 1'b1 == pos_reg) : (rd_val_reg == key_reg)) begin
                found_reg <= 1'b1; done_reg <= 1'b1;
                hit_reg <= cur_reg; hit_link_reg <= rd_link_reg;
                found_val_reg <= rd_val_reg;
            end else begin
                prev_reg <= cur_reg; cur_reg <= rd_link_reg;
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg + 1'b1 >= count_reg) done_reg <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.deliver) begin
            read_value_reg <= '0;
            status_reg <= ST_OK;
            count_out_reg <= 9'(count_reg);
            case (op_reg)
                OP_INS_FRONT, OP_INS_END, OP_INS_AFTER: begin
                    if (full) status_reg <= ST_FULL;
                    else if (op_reg == OP_INS_AFTER && !found_reg)
                        status_reg <= ST_NOT_FOUND;
                    else count_out_reg <= 9'(count_reg + 1'b1);
                end
                OP_DEL_VALUE: begin
                    if (found_reg) count_out_reg <= 9'(count_reg - 1'b1);
                    else status_reg <= ST_NOT_FOUND;
                end
                OP_DEL_FIRST: begin
                    if (count_reg != '0) count_out_reg <= 9'(count_reg - 1'b1);
                    else status_reg <= ST_NOT_FOUND;
                end
                OP_SEARCH: if (!found_reg) status_reg <= ST_NOT_FOUND;
                OP_READ_AT: begin
                    if (pos_reg == '0 || pos_reg > count_reg) status_reg <= ST_BAD_POS;
                    else read_value_reg <= 32'(signed'(found_val_reg));
                end
                default: ;
            endcase
        end
    end

    assign m_status = status_reg;
    assign m_read_value = read_value_reg;
    assign m_entry_count = count_out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP) else $error("count above capacity");
    a_free_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(count_reg) + 32'(free_top_reg)) == LIST_CAPACITY)
        else $error("free stack and count disagree");
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_eval |-> (idx_reg < count_reg)) else $error("walk past end");
endmodule

// File: sv/ordered_list_engine.sv
`timescale 1ns / 1ps
// channel   ports                                              direction
// request   s_valid s_ready s_op s_item_value s_anchor_value s_position  in
// result    m_valid m_ready m_status m_read_value m_entry_count        out
//
// one request at a time; insert front/end and delete first need no list walk
// value walks (search, delete, insert after, read at) visit entries in list order,
// one node store read each, up to count entries
// after reset a clearing pass fills the free stack before the first request is taken
// a result stalled on m_ready still lets the next request in; its result then holds the engine in its final state
module ordered_list_engine #(
    parameter int LIST_CAPACITY = ole_pkg::DEF_CAPACITY,
    parameter int VALUE_WIDTH   = ole_pkg::DEF_VALUE_WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_op,
    input  logic signed [31:0] s_item_value,
    input  logic signed [31:0] s_anchor_value,
    input  logic [8:0]         s_position,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_read_value,
    output logic [8:0]         m_entry_count
);
    import ole_pkg::*;

    ole_cmd_t  cmd;
    ole_stat_t stat;

    ole_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .stat(stat), .cmd(cmd)
    );

    ole_datapath #(.LIST_CAPACITY(LIST_CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .s_op(s_op), .s_item_value(s_item_value), .s_anchor_value(s_anchor_value),
        .s_position(s_position), .m_status(m_status), .m_read_value(m_read_value),
        .m_entry_count(m_entry_count)
    );
endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import ole_pkg::*;

    localparam int CAP = 256;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_op = '0;
    logic signed [31:0] s_item_value = '0;
    logic signed [31:0] s_anchor_value = '0;
    logic [8:0]         s_position = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic signed [31:0] m_read_value;
    logic [8:0]         m_entry_count;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [8:0]  count;
    } list_result_t;

    list_result_t pending_results[$];
    logic [31:0]  list_shadow[$];   // entries in list order, head first
    int           error_count = 0;
    int           sent_count = 0;
    int           checked_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    ordered_list_engine DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_op(s_op),
        .s_item_value(s_item_value), .s_anchor_value(s_anchor_value),
        .s_position(s_position),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_read_value(m_read_value), .m_entry_count(m_entry_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int find_entry(logic [31:0] v);
        for (int i = 0; i < list_shadow.size(); i++)
            if (list_shadow[i] == v) return i;
        return -1;
    endfunction

    // list operation applied to the shadow copy, yields the expected result
    function automatic list_result_t apply_list_op(logic [2:0] op, logic [31:0] item,
                                                   logic [31:0] anchor, logic [8:0] pos);
        list_result_t r;
        int idx;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INS_FRONT, OP_INS_END, OP_INS_AFTER: begin
                if (list_shadow.size() >= CAP) begin
                    r.status = ST_FULL;
                end else if (op == OP_INS_FRONT) begin
                    list_shadow.push_front(item);
                end else if (op == OP_INS_END) begin
                    list_shadow.push_back(item);
                end else begin
                    idx = find_entry(anchor);
                    if (idx < 0) r.status = ST_NOT_FOUND;
                    else list_shadow.insert(idx + 1, item);
                end
            end
            OP_DEL_VALUE: begin
                idx = find_entry(item);
                if (idx < 0) r.status = ST_NOT_FOUND;
                else list_shadow.delete(idx);
            end
            OP_DEL_FIRST: begin
                if (list_shadow.size() == 0) r.status = ST_NOT_FOUND;
                else void'(list_shadow.pop_front());
            end
            OP_SEARCH: begin
                if (find_entry(item) < 0) r.status = ST_NOT_FOUND;
            end
            OP_READ_AT: begin
                if (pos == 0 || pos > list_shadow.size()) r.status = ST_BAD_POS;
                else r.value = list_shadow[pos - 1];
            end
            default: ;
        endcase
        r.count = 9'(list_shadow.size());
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // valid drops only while the sender idles, so each edge sees one update
    task automatic send_request(logic [2:0] op, logic [31:0] item,
                                logic [31:0] anchor = '0, logic [8:0] pos = '0);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_op           <= op;
        s_item_value   <= item;
        s_anchor_value <= anchor;
        s_position     <= pos;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(apply_list_op(op, item, anchor, pos));
        sent_count++;
    endtask

    always @(posedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transaction", {30'd0, m_status}, 0);
            end else begin
                want = pending_results.pop_front();
                checked_count++;
                if (m_status !== want.status)
                    report_mismatch("status", {30'd0, m_status}, {30'd0, want.status});
                if (m_read_value !== want.value)
                    report_mismatch("read_value", m_read_value, want.value);
                if (m_entry_count !== want.count)
                    report_mismatch("entry_count", {23'd0, m_entry_count},
                                    {23'd0, want.count});
            end
        end
    end

    function automatic logic [31:0] pick_value();
        // favor values already on the list so searches and deletes hit
        if (list_shadow.size() > 0 && $urandom_range(99) < 60)
            return list_shadow[$urandom_range(list_shadow.size() - 1)];
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_request(OP_DEL_FIRST, 0);
        send_request(OP_SEARCH, 5);
        send_request(OP_READ_AT, 0, 0, 1);
        send_request(OP_INS_AFTER, 1, 2);
        send_request(OP_INS_FRONT, 32'h8000_0000);
        send_request(OP_INS_END, 32'h7fff_ffff);
        send_request(OP_INS_AFTER, 32'hffff_ffff, 32'h8000_0000);
        send_request(OP_INS_AFTER, 32'h5555_aaaa, 32'h7fff_ffff);
        send_request(OP_INS_AFTER, 3, 99);
        send_request(OP_READ_AT, 0, 0, 0);
        send_request(OP_READ_AT, 0, 0, 1);
        send_request(OP_READ_AT, 0, 0, 4);
        send_request(OP_READ_AT, 0, 0, 5);
        send_request(OP_READ_AT, 0, 0, 9'h1ff);
        send_request(OP_SEARCH, 32'hffff_ffff);
        send_request(OP_DEL_VALUE, 32'h5555_aaaa);
        send_request(3'd7, 32'hffff_ffff, 32'hffff_ffff, 9'h1ff);
        send_request(OP_DEL_VALUE, 42);
        send_request(OP_DEL_FIRST, 0);
        send_request(OP_READ_AT, 0, 0, 2);
    endtask

    // fill to capacity, poke the full store, then drain
    task automatic test_full_store();
        while (list_shadow.size() < CAP)
            send_request($urandom_range(1) ? OP_INS_END : OP_INS_FRONT, $urandom);
        send_request(OP_INS_FRONT, 1);
        send_request(OP_INS_END, 2);
        send_request(OP_INS_AFTER, 3, list_shadow[0]);
        send_request(OP_READ_AT, 0, 0, 9'd256);
        send_request(OP_READ_AT, 0, 0, 9'd257);
        send_request(OP_SEARCH, list_shadow[CAP - 1]);
        send_request(OP_DEL_VALUE, list_shadow[CAP - 1]);
        while (list_shadow.size() > 0) send_request(OP_DEL_FIRST, 0);
    endtask

    task automatic test_random(int n);
        logic [2:0] op;
        for (int i = 0; i < n; i++) begin
            op = 3'($urandom_range(7));
            if (op == 3'd7 && $urandom_range(3) != 0) op = OP_SEARCH;
            // keep lists short most of the time so walks stay cheap
            if (list_shadow.size() > 24 && op <= OP_INS_AFTER && $urandom_range(1))
                op = OP_DEL_FIRST;
            send_request(op, pick_value(), pick_value(),
                         9'($urandom_range(list_shadow.size() + 1)));
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_full_store();
        send_idle_pct = 0;  recv_stall_pct = 0;  test_random(220);
        send_idle_pct = 46; recv_stall_pct = 0;  test_random(220);
        send_idle_pct = 0;  recv_stall_pct = 46; test_random(220);
        send_idle_pct = 13; recv_stall_pct = 13; test_random(220);
        s_valid <= 1'b0;
        send_idle_pct = 0;  recv_stall_pct = 0;
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
        $display("%0d requests sent, %0d results checked, incl. full store and all ops",
                 sent_count, checked_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end
endmodule
